FILE: hw/rtl/dfs_pkg.sv
package dfs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_CFG_W   = 5;
    localparam int LEN_W       = (CNT_W > LEN_CFG_W) ? CNT_W : LEN_CFG_W;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int TIDX_W   = 4;
    localparam int KHZ_W    = 24;
    localparam int CYC_W    = 40;
    localparam int NS_W     = 48;
    localparam int DLY_W    = 32;
    localparam int STS_W    = 3;

    localparam logic [KHZ_W-1:0] KHZ_MAX = {KHZ_W{1'b1}};

    // Input tdata layout, lowest bit first
    localparam int OFF_TIDX  = 0;
    localparam int OFF_TKHZ  = OFF_TIDX + TIDX_W;
    localparam int OFF_TVAL  = OFF_TKHZ + KHZ_W;
    localparam int OFF_CYC   = OFF_TVAL + 1;
    localparam int OFF_TMIN  = OFF_CYC + CYC_W;
    localparam int OFF_DL    = OFF_TMIN + KHZ_W;
    localparam int OFF_TICK  = OFF_DL + NS_W;
    localparam int OFF_DLY   = OFF_TICK + NS_W;
    localparam int OFF_REQ   = OFF_DLY + DLY_W;
    localparam int IN_BITS   = OFF_REQ + KHZ_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Output layout
    localparam int OUT_TDATA_W = 2 * KHZ_W;
    localparam int OUT_TUSER_W = 1 + STS_W;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LEN  = 2'd2;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TABLE_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEADLINE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIRECT_SET  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_USER_SET    = 2'd3;

    // Result status
    localparam logic [STS_W-1:0] STS_ACCEPTED      = 3'd0;
    localparam logic [STS_W-1:0] STS_BELOW_MIN     = 3'd1;
    localparam logic [STS_W-1:0] STS_MISSED        = 3'd2;
    localparam logic [STS_W-1:0] STS_NO_WORK       = 3'd3;
    localparam logic [STS_W-1:0] STS_TABLE_WRITTEN = 3'd4;

    // Shared adder width: cycles * 1e6 needs 60 bits, remaining << 24 needs 72
    localparam int ALU_W  = NS_W + KHZ_W;
    localparam int STEP_W = $clog2(KHZ_W);

    // Set bits of 1000000: multiply by shift-and-add over these only
    localparam int MUL_STEPS  = 7;
    localparam int MSTEP_W    = $clog2(MUL_STEPS);
    localparam logic [4:0] MUL_SHIFT [MUL_STEPS] =
        '{5'd19, 5'd18, 5'd17, 5'd16, 5'd14, 5'd9, 5'd6};

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } alu_rsp_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [KHZ_W-1:0] khz;
        logic             valid;
    } tbl_wr_t;

endpackage

FILE: hw/rtl/deadline_frequency_selector.sv
// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid/s_tready  | s_tuser: kind; s_tdata: table write, deadline, set fields
// m_       | out | m_tvalid/m_tready  | m_tdata: selected_khz, current_khz; m_tuser: changed, status
// cfg_     | in  | cfg_valid/cfg_ready| cfg_index: register, cfg_data: value (always ready)
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Table write or no-work request: straight to the result. Direct/user set: a scan of up to
// TABLE_DEPTH entries, one table entry per cycle. Deadline request: add, compare, 7 multiply
// and 24 divide steps on the shared 72-bit adder, then the scan; if missed, entry 0 is taken.
// A result waits in the output register until taken; the next item is accepted meanwhile.
// aresetn (synchronous, active low) clears the table and current frequency, and resets the config.
module deadline_frequency_selector (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // table_index, table_khz, table_entry_valid, cycles_left, task_min_khz,
    // due_ns, tick_ns, monitor_delay_ns, requested_khz, zero pad
    input  logic [dfs_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind
    input  logic [dfs_pkg::KIND_W-1:0]         s_tuser,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // selected_khz, current_khz
    output logic [dfs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // changed, status
    output logic [dfs_pkg::OUT_TUSER_W-1:0]    m_tuser,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dfs_pkg::KHZ_W-1:0]          cfg_data
);
    import dfs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_REM  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SAT  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // Input fields
    logic [TIDX_W-1:0] in_tidx;
    logic [KHZ_W-1:0]  in_tkhz;
    logic              in_tval;
    logic [CYC_W-1:0]  in_cyc;
    logic [KHZ_W-1:0]  in_tmin;
    logic [NS_W-1:0]   in_dl;
    logic [NS_W-1:0]   in_tick;
    logic [DLY_W-1:0]  in_dly;
    logic [KHZ_W-1:0]  in_req;

    assign in_tidx = s_tdata[OFF_TIDX +: TIDX_W];
    assign in_tkhz = s_tdata[OFF_TKHZ +: KHZ_W];
    assign in_tval = s_tdata[OFF_TVAL];
    assign in_cyc  = s_tdata[OFF_CYC +: CYC_W];
    assign in_tmin = s_tdata[OFF_TMIN +: KHZ_W];
    assign in_dl   = s_tdata[OFF_DL +: NS_W];
    assign in_tick = s_tdata[OFF_TICK +: NS_W];
    assign in_dly  = s_tdata[OFF_DLY +: DLY_W];
    assign in_req  = s_tdata[OFF_REQ +: KHZ_W];

    // Control registers
    logic [2:0]           state_reg, state_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [KHZ_W-1:0]     oper_reg, oper_next;
    logic [KHZ_W-1:0]     pmin_reg;
    logic [KHZ_W-1:0]     pmax_reg;
    logic [LEN_CFG_W-1:0] cfg_len_reg;

    // Datapath registers
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [CYC_W-1:0]     cycles_reg, cycles_next;
    logic [KHZ_W-1:0]     tmin_reg, tmin_next;
    logic [NS_W-1:0]      dl_reg, dl_next;
    logic [ALU_W-1:0]     acc_reg, acc_next;
    logic [ALU_W-1:0]     div_reg, div_next;
    logic [KHZ_W-1:0]     quo_reg, quo_next;
    logic [KHZ_W-1:0]     pick_reg, pick_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [LEN_W-1:0]     cnt_reg, cnt_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 missed_reg, missed_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    alu_req_t         alu_req;
    alu_rsp_t         alu_rsp;
    tbl_wr_t          tbl_wr;
    logic [KHZ_W-1:0] rd_khz;
    logic             rd_valid;
    logic [KHZ_W-1:0] head_khz;
    logic [LEN_W-1:0] len_ext;
    logic             usable;
    logic             out_free;
    logic             accept;
    logic [STS_W-1:0] sts;
    logic [KHZ_W-1:0] sel;

    dfs_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    dfs_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (tbl_wr),
        .rd_addr  (cnt_reg[IDX_W-1:0]),
        .rd_khz   (rd_khz),
        .rd_valid (rd_valid),
        .head_khz (head_khz)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign len_ext  = LEN_W'(cfg_len_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign usable   = rd_valid && (rd_khz >= pmin_reg) && (rd_khz <= pmax_reg);

    // Shared adder operand select
    always_comb begin
        alu_req.a   = acc_reg;
        alu_req.b   = div_reg;
        alu_req.sub = 1'b1;
        case (state_reg)
            S_IDLE: begin
                alu_req.a   = ALU_W'(in_tick);
                alu_req.b   = ALU_W'(in_dly);
                alu_req.sub = 1'b0;
            end
            S_REM: begin
                alu_req.a = ALU_W'(dl_reg);
                alu_req.b = acc_reg;
            end
            S_MUL: begin
                alu_req.b   = ALU_W'(cycles_reg) << MUL_SHIFT[step_reg[MSTEP_W-1:0]];
                alu_req.sub = 1'b0;
            end
            default: begin
                alu_req.a   = acc_reg;
                alu_req.b   = div_reg;
                alu_req.sub = 1'b1;
            end
        endcase
    end

    // Outcome of the finished item
    always_comb begin
        accept = 1'b0;
        sts    = STS_ACCEPTED;
        sel    = pick_reg;
        case (kind_reg)
            KIND_TABLE_WRITE: begin
                sts = STS_TABLE_WRITTEN;
                sel = '0;
            end
            KIND_DEADLINE: begin
                if (cycles_reg == '0) begin
                    sts = STS_NO_WORK;
                    sel = '0;
                end else if (pick_reg < tmin_reg) begin
                    sts = STS_BELOW_MIN;
                end else begin
                    accept = 1'b1;
                    sts    = missed_reg ? STS_MISSED : STS_ACCEPTED;
                end
            end
            KIND_DIRECT_SET: begin
                if (pick_reg < tmin_reg) begin
                    sts = STS_BELOW_MIN;
                end else begin
                    accept = 1'b1;
                end
            end
            default: begin
                accept = 1'b1;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        oper_next     = oper_reg;
        kind_next     = kind_reg;
        cycles_next   = cycles_reg;
        tmin_next     = tmin_reg;
        dl_next       = dl_reg;
        acc_next      = acc_reg;
        div_next      = div_reg;
        quo_next      = quo_reg;
        pick_next     = pick_reg;
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        missed_next   = missed_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        tbl_wr.en    = 1'b0;
        tbl_wr.addr  = IDX_W'({{IDX_W{1'b0}}, in_tidx});
        tbl_wr.khz   = in_tkhz;
        tbl_wr.valid = in_tval;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next   = s_tuser;
                    cycles_next = in_cyc;
                    tmin_next   = in_tmin;
                    dl_next     = in_dl;
                    acc_next    = alu_rsp.sum;
                    quo_next    = in_req;
                    pick_next   = head_khz;
                    missed_next = 1'b0;
                    step_next   = '0;
                    cnt_next    = '0;
                    len_next    = (len_ext > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                                  : len_ext;
                    case (s_tuser)
                        KIND_TABLE_WRITE: begin
                            // Writes beyond the table depth are dropped
                            tbl_wr.en  = ({{IDX_W{1'b0}}, in_tidx} <
                                          (IDX_W + TIDX_W)'(TABLE_DEPTH));
                            state_next = S_FIN;
                        end
                        KIND_DEADLINE: begin
                            state_next = (in_cyc == '0) ? S_FIN : S_REM;
                        end
                        default: begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_REM: begin
                // Deadline reached or passed: take entry 0 without a scan
                if (!alu_rsp.carry || alu_rsp.sum == '0) begin
                    missed_next = 1'b1;
                    pick_next   = head_khz;
                    state_next  = S_FIN;
                end else begin
                    div_next   = {alu_rsp.sum[ALU_W-KHZ_W-1:0], {KHZ_W{1'b0}}};
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                acc_next  = alu_rsp.sum;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MUL_STEPS - 1)) begin
                    state_next = S_SAT;
                end
            end
            S_SAT: begin
                // Quotient would not fit in 24 bits: saturate the target
                if (alu_rsp.carry) begin
                    quo_next   = KHZ_MAX;
                    state_next = S_SCAN;
                end else begin
                    div_next   = div_reg >> 1;
                    step_next  = STEP_W'(KHZ_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (alu_rsp.carry) begin
                    acc_next = alu_rsp.sum;
                end
                quo_next = {quo_reg[KHZ_W-2:0], alu_rsp.carry};
                div_next = div_reg >> 1;
                if (step_reg == '0) begin
                    state_next = S_SCAN;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_SCAN: begin
                if (cnt_reg >= len_reg) begin
                    state_next = S_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                    if (usable && rd_khz < quo_reg) begin
                        state_next = S_FIN;
                    end else if (usable) begin
                        pick_next = rd_khz;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    if (accept && sel != oper_reg) begin
                        oper_next = sel;
                    end
                    m_tdata_next  = {(accept && sel != oper_reg) ? sel : oper_reg, sel};
                    m_tuser_next  = {sts, accept && sel != oper_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            oper_reg     <= '0;
            pmin_reg     <= '0;
            pmax_reg     <= KHZ_MAX;
            cfg_len_reg  <= LEN_CFG_W'(1);
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            oper_reg     <= oper_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_POLICY_MIN: pmin_reg    <= cfg_data;
                    CFG_POLICY_MAX: pmax_reg    <= cfg_data;
                    CFG_TABLE_LEN:  cfg_len_reg <= cfg_data[LEN_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        cycles_reg  <= cycles_next;
        tmin_reg    <= tmin_next;
        dl_reg      <= dl_next;
        acc_reg     <= acc_next;
        div_reg     <= div_next;
        quo_reg     <= quo_next;
        pick_reg    <= pick_next;
        step_reg    <= step_next;
        cnt_reg     <= cnt_next;
        len_reg     <= len_next;
        missed_reg  <= missed_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

FILE: hw/rtl/dfs_alu.sv
module dfs_alu (
    input  dfs_pkg::alu_req_t req,
    output dfs_pkg::alu_rsp_t rsp
);
    import dfs_pkg::*;

    logic [ALU_W-1:0] b_op;

    // Subtract as a + ~b + 1; carry high means a >= b
    assign b_op = req.sub ? ~req.b : req.b;
    assign {rsp.carry, rsp.sum} = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};

endmodule

FILE: hw/rtl/dfs_table.sv
module dfs_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dfs_pkg::tbl_wr_t             wr,
    input  logic [dfs_pkg::IDX_W-1:0]    rd_addr,
    output logic [dfs_pkg::KHZ_W-1:0]    rd_khz,
    output logic                         rd_valid,
    output logic [dfs_pkg::KHZ_W-1:0]    head_khz
);
    import dfs_pkg::*;

    logic [KHZ_W-1:0] khz_reg   [TABLE_DEPTH];
    logic             valid_reg [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                khz_reg[i]   <= '0;
                valid_reg[i] <= 1'b0;
            end
        end else if (wr.en) begin
            khz_reg[wr.addr]   <= wr.khz;
            valid_reg[wr.addr] <= wr.valid;
        end
    end

    assign rd_khz   = khz_reg[rd_addr];
    assign rd_valid = valid_reg[rd_addr];
    assign head_khz = khz_reg[0];

endmodule

FILE: hw/rtl/dfs_checker.sv
module dfs_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dfs_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [dfs_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import dfs_pkg::*;

    logic [KHZ_W-1:0] last_cur_reg;

    // Hold the current frequency of the last taken beat; zero out of reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_cur_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            last_cur_reg <= m_tdata[OUT_TDATA_W-1:KHZ_W];
        end
    end

    // A switch always lands on the frequency that was selected
    a_changed_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[KHZ_W-1:0] == m_tdata[OUT_TDATA_W-1:KHZ_W])
        else $error("changed beat with current != selected");

    // Table writes and no-work requests select nothing and switch nothing
    a_passive_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[OUT_TUSER_W-1:1] == STS_TABLE_WRITTEN ||
                     m_tuser[OUT_TUSER_W-1:1] == STS_NO_WORK)
        |-> m_tdata[KHZ_W-1:0] == '0 && !m_tuser[0])
        else $error("table write or no-work beat reports a selection");

    // A rejected choice never switches the frequency
    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[OUT_TUSER_W-1:1] == STS_BELOW_MIN |-> !m_tuser[0])
        else $error("below-minimum beat switched the frequency");

    // Current frequency only moves on a changed beat
    a_current_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[0] == (m_tdata[OUT_TDATA_W-1:KHZ_W] != last_cur_reg))
        else $error("current frequency moved without a change");

    // Stalled beat holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind deadline_frequency_selector dfs_checker u_dfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/freq_choice_checker.sv
module freq_choice_checker (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [dfs_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [dfs_pkg::KIND_W-1:0]      s_tuser,

    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dfs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [dfs_pkg::OUT_TUSER_W-1:0] m_tuser,

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dfs_pkg::KHZ_W-1:0]       cfg_data,

    output int                              mismatches,
    output int                              outstanding
);
    import dfs_pkg::*;

    typedef struct packed {
        logic [KHZ_W-1:0] selected_khz;
        logic [KHZ_W-1:0] current_khz;
        logic             changed;
        logic [STS_W-1:0] status;
    } freq_result_t;

    logic [KHZ_W-1:0]     freq_khz [TABLE_DEPTH];
    logic                 freq_ok  [TABLE_DEPTH];
    logic [KHZ_W-1:0]     operating_khz;
    logic [KHZ_W-1:0]     policy_min;
    logic [KHZ_W-1:0]     policy_max;
    logic [LEN_CFG_W-1:0] scan_len;

    freq_result_t awaited_results [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Walk down from entry 0; stop at the first usable entry below the target.
    function automatic logic [KHZ_W-1:0] lowest_fit_khz(input logic [KHZ_W-1:0] target);
        logic [KHZ_W-1:0] pick;
        int               n;
        pick = freq_khz[0];
        n = (scan_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_len);
        for (int i = 0; i < n; i++) begin
            if (!freq_ok[i])
                continue;
            if (freq_khz[i] < policy_min || freq_khz[i] > policy_max)
                continue;
            if (freq_khz[i] < target)
                break;
            pick = freq_khz[i];
        end
        return pick;
    endfunction

    function automatic freq_result_t choose_frequency(input logic [KIND_W-1:0] kind,
                                                      input logic [IN_TDATA_W-1:0] d);
        logic [TIDX_W-1:0] t_idx;
        logic [KHZ_W-1:0]  t_khz;
        logic              t_ok;
        logic [CYC_W-1:0]  cyc;
        logic [KHZ_W-1:0]  t_min;
        logic [NS_W-1:0]   dl;
        logic [NS_W-1:0]   tick;
        logic [DLY_W-1:0]  dly;
        logic [KHZ_W-1:0]  req;
        logic [NS_W:0]     now_ns;
        logic [NS_W-1:0]   left_ns;
        logic [63:0]       target;
        logic              accept;
        logic              missed;
        freq_result_t      r;
        t_idx = d[OFF_TIDX +: TIDX_W];
        t_khz = d[OFF_TKHZ +: KHZ_W];
        t_ok  = d[OFF_TVAL];
        cyc   = d[OFF_CYC  +: CYC_W];
        t_min = d[OFF_TMIN +: KHZ_W];
        dl    = d[OFF_DL   +: NS_W];
        tick  = d[OFF_TICK +: NS_W];
        dly   = d[OFF_DLY  +: DLY_W];
        req   = d[OFF_REQ  +: KHZ_W];
        r = '0;
        accept = 1'b0;
        case (kind)
            KIND_TABLE_WRITE: begin
                freq_khz[t_idx] = t_khz;
                freq_ok[t_idx]  = t_ok;
                r.status = STS_TABLE_WRITTEN;
            end
            KIND_DEADLINE: begin
                if (cyc == '0) begin
                    r.status = STS_NO_WORK;
                end else begin
                    now_ns = {1'b0, tick} + {{(NS_W + 1 - DLY_W){1'b0}}, dly};
                    missed = ({1'b0, dl} <= now_ns);
                    if (missed) begin
                        r.selected_khz = freq_khz[0];
                    end else begin
                        left_ns = dl - now_ns[NS_W-1:0];
                        target = ({24'b0, cyc} * 64'd1000000) / {16'b0, left_ns};
                        if (target > KHZ_MAX)
                            target = 64'(KHZ_MAX);
                        r.selected_khz = lowest_fit_khz(target[KHZ_W-1:0]);
                    end
                    if (r.selected_khz >= t_min) begin
                        accept = 1'b1;
                        r.status = missed ? STS_MISSED : STS_ACCEPTED;
                    end else begin
                        r.status = STS_BELOW_MIN;
                    end
                end
            end
            KIND_DIRECT_SET: begin
                r.selected_khz = lowest_fit_khz(req);
                if (r.selected_khz >= t_min) begin
                    accept = 1'b1;
                    r.status = STS_ACCEPTED;
                end else begin
                    r.status = STS_BELOW_MIN;
                end
            end
            default: begin
                r.selected_khz = lowest_fit_khz(req);
                accept = 1'b1;
                r.status = STS_ACCEPTED;
            end
        endcase
        if (accept && r.selected_khz != operating_khz) begin
            operating_khz = r.selected_khz;
            r.changed = 1'b1;
        end
        r.current_khz = operating_khz;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [KHZ_W-1:0] exp_v,
                               input logic [KHZ_W-1:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        freq_result_t exp_r;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                freq_khz[i] = '0;
                freq_ok[i]  = 1'b0;
            end
            operating_khz = '0;
            policy_min    = '0;
            policy_max    = KHZ_MAX;
            scan_len      = LEN_CFG_W'(1);
            awaited_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_POLICY_MIN: policy_min = cfg_data;
                    CFG_POLICY_MAX: policy_max = cfg_data;
                    CFG_TABLE_LEN:  scan_len   = cfg_data[LEN_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected, expected nothing, got %h/%h",
                             $time, m_tdata, m_tuser);
                end else begin
                    exp_r = awaited_results.pop_front();
                    check_field("selected_khz", exp_r.selected_khz, m_tdata[0 +: KHZ_W]);
                    check_field("current_khz", exp_r.current_khz, m_tdata[KHZ_W +: KHZ_W]);
                    check_field("changed", KHZ_W'(exp_r.changed), KHZ_W'(m_tuser[0]));
                    check_field("status", KHZ_W'(exp_r.status), KHZ_W'(m_tuser[1 +: STS_W]));
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(choose_frequency(s_tuser, s_tdata));
        end
        outstanding = awaited_results.size();
    end

endmodule

FILE: tb/sv/tb_deadline_frequency_selector.sv
module tb_deadline_frequency_selector;
    import dfs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 230;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIDX_W-1:0] table_index;
        logic [KHZ_W-1:0]  table_khz;
        logic              table_entry_valid;
        logic [CYC_W-1:0]  cycles_left;
        logic [KHZ_W-1:0]  task_min_khz;
        logic [NS_W-1:0]   due_ns;
        logic [NS_W-1:0]   tick_ns;
        logic [DLY_W-1:0]  monitor_delay_ns;
        logic [KHZ_W-1:0]  requested_khz;
    } freq_request_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [KIND_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [KHZ_W-1:0]       cfg_data  = '0;

    int mismatches;
    int outstanding;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_seq   = 0;

    deadline_frequency_selector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    freq_choice_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever hold_seq moves.
    initial begin
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_tready <= rx_idle_on ? ($urandom_range(99) >= 6) : 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_request(input freq_request_t r);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[OFF_TIDX +: TIDX_W] = r.table_index;
        d[OFF_TKHZ +: KHZ_W]  = r.table_khz;
        d[OFF_TVAL]           = r.table_entry_valid;
        d[OFF_CYC  +: CYC_W]  = r.cycles_left;
        d[OFF_TMIN +: KHZ_W]  = r.task_min_khz;
        d[OFF_DL   +: NS_W]   = r.due_ns;
        d[OFF_TICK +: NS_W]   = r.tick_ns;
        d[OFF_DLY  +: DLY_W]  = r.monitor_delay_ns;
        d[OFF_REQ  +: KHZ_W]  = r.requested_khz;
        return d;
    endfunction

    function automatic freq_request_t blank_request(input logic [KIND_W-1:0] kind);
        freq_request_t r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    // Roughly descending ladder so that scans walk several entries.
    function automatic logic [KHZ_W-1:0] ladder_khz(input logic [TIDX_W-1:0] idx);
        int khz;
        khz = (TABLE_DEPTH - int'(idx)) * 1000000 + $urandom_range(0, 400000);
        return khz[KHZ_W-1:0];
    endfunction

    function automatic logic [KHZ_W-1:0] pick_task_min();
        int p;
        p = $urandom_range(99);
        if (p < 65)
            return '0;
        else if (p < 90)
            return KHZ_W'($urandom_range(0, 12_000_000));
        return KHZ_W'($urandom);
    endfunction

    function automatic freq_request_t make_request();
        freq_request_t r;
        logic [63:0]   left_ns;
        logic [63:0]   target;
        int            pick;
        int            mode;
        // start from noise in every field, then shape the ones the kind uses
        r.kind              = KIND_TABLE_WRITE;
        r.table_index       = TIDX_W'($urandom);
        r.table_khz         = KHZ_W'($urandom);
        r.table_entry_valid = 1'($urandom);
        r.cycles_left       = CYC_W'(rand64());
        r.task_min_khz      = KHZ_W'($urandom);
        r.due_ns            = NS_W'(rand64());
        r.tick_ns           = NS_W'(rand64());
        r.monitor_delay_ns  = $urandom;
        r.requested_khz     = KHZ_W'($urandom);
        pick = $urandom_range(99);
        mode = $urandom_range(99);
        if (pick < 25) begin
            if (mode < 80)
                r.table_khz = ladder_khz(r.table_index);
            else if (mode < 85)
                r.table_khz = '0;
            else if (mode < 90)
                r.table_khz = KHZ_MAX;
            r.table_entry_valid = ($urandom_range(99) < 85);
            return r;
        end
        r.task_min_khz = pick_task_min();
        if (pick < 60) begin
            r.kind = KIND_DEADLINE;
            if (mode < 87) begin
                r.tick_ns          = NS_W'(rand64() & 64'h7FFF_FFFF_FFFF);
                r.monitor_delay_ns = $urandom >> $urandom_range(0, 31);
                left_ns = 64'($urandom_range(1, 2_000_000));
                target  = 64'($urandom_range(0, 16_777_215));
                if (mode < 65 || mode >= 75)
                    r.cycles_left = CYC_W'((target * left_ns) / 64'd1000000);
                else
                    r.cycles_left = CYC_W'(rand64() >> $urandom_range(0, 39));
                if (mode < 75)
                    r.due_ns = NS_W'(r.tick_ns + r.monitor_delay_ns + left_ns);
                else
                    r.due_ns = r.tick_ns + r.monitor_delay_ns - $urandom_range(0, 1000);
            end else if (mode < 92) begin
                r.cycles_left = '0;
            end
        end else if (pick < 80) begin
            r.kind = KIND_DIRECT_SET;
        end else begin
            r.kind = KIND_USER_SET;
            r.task_min_khz = KHZ_W'($urandom);
        end
        return r;
    endfunction

    task automatic send_request(input freq_request_t r);
        while (tx_idle_on && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= pack_request(r);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KHZ_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_policy(input logic [KHZ_W-1:0] lo, input logic [KHZ_W-1:0] hi,
                              input logic [LEN_CFG_W-1:0] len, input bit spare);
        write_reg(CFG_POLICY_MIN, lo);
        write_reg(CFG_POLICY_MAX, hi);
        write_reg(CFG_TABLE_LEN, KHZ_W'(len));
        if (spare)
            write_reg(CFG_SPARE, KHZ_W'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop valid and hold until every result is back and the block is quiet.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        freq_request_t   r;
        logic [KHZ_W-1:0] lo;
        logic [KHZ_W-1:0] hi;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset policy: only entry 0 is scanned, table empty.
        r = blank_request(KIND_DEADLINE);
        r.cycles_left = '0;
        send_request(r);
        r = blank_request(KIND_DEADLINE);
        r.cycles_left = 40'd1000;
        send_request(r);
        r = blank_request(KIND_USER_SET);
        r.requested_khz = KHZ_MAX;
        send_request(r);
        r = blank_request(KIND_TABLE_WRITE);
        r.table_index = 4'd0;
        r.table_khz = KHZ_MAX;
        r.table_entry_valid = 1'b1;
        send_request(r);
        r.table_index = 4'd1;
        r.table_khz = 24'd8_000_000;
        send_request(r);
        r.table_index = 4'd2;
        r.table_khz = 24'd4_000_000;
        r.table_entry_valid = 1'b0;
        send_request(r);
        r.table_index = 4'd3;
        r.table_khz = 24'd2_000_000;
        r.table_entry_valid = 1'b1;
        send_request(r);
        r.table_index = 4'd15;
        r.table_khz = '0;
        send_request(r);
        r = blank_request(KIND_DIRECT_SET);
        send_request(r);
        drain_results();

        set_policy('0, KHZ_MAX, LEN_CFG_W'(TABLE_DEPTH), 1'b0);
        r = blank_request(KIND_USER_SET);
        send_request(r);
        r.requested_khz = 24'd3_000_000;
        send_request(r);
        r = blank_request(KIND_DIRECT_SET);
        r.requested_khz = 24'd3_000_000;
        r.task_min_khz = KHZ_MAX;
        send_request(r);
        // target far above the top entry: saturate
        r = blank_request(KIND_DEADLINE);
        r.cycles_left = {CYC_W{1'b1}};
        r.due_ns = 48'd1;
        send_request(r);
        r.tick_ns = {NS_W{1'b1}};
        r.monitor_delay_ns = {DLY_W{1'b1}};
        r.due_ns = {NS_W{1'b1}};
        send_request(r);
        // entry 0 invalid and low: missed deadline falls below the task minimum
        r = blank_request(KIND_TABLE_WRITE);
        r.table_khz = 24'd1000;
        send_request(r);
        r = blank_request(KIND_DEADLINE);
        r.cycles_left = 40'd5;
        r.task_min_khz = 24'd5000;
        r.tick_ns = 48'd100;
        r.due_ns = 48'd100;
        send_request(r);
        r = blank_request(KIND_USER_SET);
        r.requested_khz = 24'd9_000_000;
        send_request(r);
        r = blank_request(KIND_DEADLINE);
        r.cycles_left = 40'd4000;
        r.tick_ns = 48'd500;
        r.monitor_delay_ns = 32'd500;
        r.due_ns = 48'd2000;
        send_request(r);
        r = blank_request(KIND_USER_SET);
        r.requested_khz = 24'd5_000_000;
        send_request(r);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            tx_idle_on <= (p != 3);
            rx_idle_on <= (p != 3);
            case (p)
                0: set_policy('0, KHZ_MAX, LEN_CFG_W'(16), 1'b0);
                1: set_policy('0, KHZ_MAX, LEN_CFG_W'(0), 1'b0);
                2: set_policy(24'd2_000_000, 24'd12_000_000, LEN_CFG_W'(16), 1'b0);
                3: set_policy('0, KHZ_MAX, LEN_CFG_W'(31), 1'b0);
                4: set_policy(KHZ_MAX, KHZ_MAX, LEN_CFG_W'(8), 1'b0);
                5: set_policy('0, '0, LEN_CFG_W'(16), 1'b0);
                6: begin
                    lo = KHZ_W'($urandom_range(0, 8_000_000));
                    hi = KHZ_W'($urandom_range(lo, 16_777_215));
                    set_policy(lo, hi, LEN_CFG_W'($urandom_range(1, 16)), 1'b1);
                end
                default: set_policy(24'd5_000_000, 24'd9_000_000, LEN_CFG_W'(17), 1'b0);
            endcase
            if (p == 2)
                hold_seq <= hold_seq + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(make_request());
            drain_results();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/dfs_pkg.sv
hw/rtl/dfs_alu.sv
hw/rtl/dfs_table.sv
hw/rtl/deadline_frequency_selector.sv
hw/rtl/dfs_checker.sv
tb/sv/freq_choice_checker.sv
tb/sv/tb_deadline_frequency_selector.sv
